// ===== sv/cell_voltage_fault_monitor_core_defines.svh =====
// Assertion macros shared by the cell voltage fault monitor RTL.
// Standalone header; no other file is needed.
`ifndef CELL_VOLTAGE_FAULT_MONITOR_CORE_DEFINES_SVH
`define CELL_VOLTAGE_FAULT_MONITOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CVFM_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cvfm same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CVFM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cvfm next-cycle check failed");

`endif

// ===== sv/cvfm_pkg.sv =====
// Types, codes and sizing constants for the cell voltage fault monitor.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cvfm_pkg;

   localparam int SLAVE_COUNT = 10;
   localparam int SLAVE_AW    = (SLAVE_COUNT > 1) ? $clog2(SLAVE_COUNT) : 1;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PW    = $clog2(RSP_DEPTH);
   localparam int RSP_CW    = $clog2(RSP_DEPTH + 1);

   // slave modes
   localparam logic [1:0] MODE_INIT   = 2'd0;
   localparam logic [1:0] MODE_NORMAL = 2'd1;
   localparam logic [1:0] MODE_ERROR  = 2'd2;

   // report kinds
   localparam logic [1:0] KIND_VOLTAGE = 2'd0;
   localparam logic [1:0] KIND_UNDER   = 2'd1;
   localparam logic [1:0] KIND_OVER    = 2'd2;
   localparam logic [1:0] KIND_TEMP    = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_LOW_LIMIT  = 2'd0;
   localparam logic [1:0] CSR_HIGH_LIMIT = 2'd1;
   localparam logic [1:0] CSR_DEBOUNCE   = 2'd2;

   localparam logic [15:0] LOW_LIMIT_RESET  = 16'd33990;
   localparam logic [15:0] HIGH_LIMIT_RESET = 16'd57103;
   localparam logic [15:0] DEBOUNCE_RESET   = 16'd0;
   localparam logic [15:0] COUNT_MAX        = 16'hFFFF;

   typedef struct packed {
      logic [3:0]  slave_index;
      logic [3:0]  cell_index;
      logic [15:0] cell_code;
      logic        thermal_alarm;
   } req_type;

   typedef struct packed {
      logic [1:0]  report_kind;
      logic [3:0]  segment_id;
      logic [3:0]  cell_number;
      logic [15:0] cell_value;
      logic        still_init;
      logic        shutdown;
      logic        last;
   } rsp_type;

   // per-slave record held in the state RAM
   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] fault_count;
   } slave_rec_type;

   localparam slave_rec_type SLAVE_REC_RESET = '{mode: MODE_INIT, fault_count: 16'd0};

   // results produced by one processed sample
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

`default_nettype wire

// ===== sv/cvfm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cvfm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/cvfm_slave_stage.sv =====
// Per-slave state stage: state RAM, valid bits, write-back forwarding and fault decision.
// Depends on cvfm_pkg, cvfm_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "cell_voltage_fault_monitor_core_defines.svh"

module cvfm_slave_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_take,
   input  wire cvfm_pkg::req_type in_item,
   input  wire logic             advance,
   input  wire logic [15:0]      low_limit,
   input  wire logic [15:0]      high_limit,
   input  wire logic [15:0]      debounce,
   output logic                  busy,
   output cvfm_pkg::push_type    push
);

   localparam int AW = cvfm_pkg::SLAVE_AW;

   logic                       s1_valid_ff, s1_valid_in;
   cvfm_pkg::req_type          s1_item_ff;
   logic [cvfm_pkg::SLAVE_COUNT-1:0] ent_valid_ff, ent_valid_in;
   logic                       lw_valid_ff, lw_valid_in;
   logic [AW-1:0]              lw_addr_ff, lw_addr_in;
   cvfm_pkg::slave_rec_type    lw_rec_ff, lw_rec_in;
   logic                       tripped_ff, tripped_in;
   logic [15:0]                otc_ff, otc_in;

   logic [$bits(cvfm_pkg::slave_rec_type)-1:0] ram_rd;
   cvfm_pkg::slave_rec_type    rec_cur, rec_new;
   logic [AW-1:0]              addr;
   logic                       in_range, proc, wr_en;
   logic [1:0]                 mode1;
   logic                       init, under, over, oor, vfault, tfault;
   logic [15:0]                cnt1;
   logic                       push_shut;

   cvfm_ram #(
      .WIDTH($bits(cvfm_pkg::slave_rec_type)),
      .DEPTH(cvfm_pkg::SLAVE_COUNT)
   ) u_state_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(addr),
      .wr_data(rec_new),
      .rd_en  (in_take),
      .rd_addr(AW'(in_item.slave_index)),
      .rd_data(ram_rd)
   );

   assign addr     = AW'(s1_item_ff.slave_index);
   assign in_range = 32'(s1_item_ff.slave_index) < 32'(cvfm_pkg::SLAVE_COUNT);
   assign proc     = s1_valid_ff && advance;
   assign wr_en    = proc && !tripped_ff && in_range;
   assign busy     = s1_valid_ff;

   // last write-back may not be in the RAM yet when this read was issued
   always_comb begin
      if (lw_valid_ff && lw_addr_ff == addr) begin
         rec_cur = lw_rec_ff;
      end else if (in_range && ent_valid_ff[addr]) begin
         rec_cur = cvfm_pkg::slave_rec_type'(ram_rd);
      end else begin
         rec_cur = cvfm_pkg::SLAVE_REC_RESET;
      end
   end

   always_comb begin
      mode1 = rec_cur.mode;
      if (s1_item_ff.cell_code != 16'd0 && rec_cur.mode == cvfm_pkg::MODE_INIT) begin
         mode1 = cvfm_pkg::MODE_NORMAL;
      end
      init  = (mode1 == cvfm_pkg::MODE_INIT);
      under = s1_item_ff.cell_code < low_limit;
      over  = s1_item_ff.cell_code >= high_limit;
      oor   = under || over;

      cnt1 = rec_cur.fault_count;
      if (mode1 == cvfm_pkg::MODE_NORMAL && oor && rec_cur.fault_count != cvfm_pkg::COUNT_MAX) begin
         cnt1 = 16'(rec_cur.fault_count + 16'd1);
      end
      vfault = (mode1 == cvfm_pkg::MODE_NORMAL) && oor && (cnt1 > debounce);
      tfault = !vfault && (otc_ff > debounce);

      rec_new.mode        = vfault ? cvfm_pkg::MODE_ERROR : mode1;
      rec_new.fault_count = cnt1;
   end

   always_comb begin
      push = '0;
      push.first.segment_id  = s1_item_ff.slave_index;
      push.first.cell_number = s1_item_ff.cell_index;
      push.first.cell_value  = s1_item_ff.cell_code;
      push.second.report_kind = cvfm_pkg::KIND_TEMP;
      push.second.shutdown    = 1'b1;
      push.second.last        = 1'b1;
      otc_in     = otc_ff;
      tripped_in = tripped_ff;
      if (vfault) begin
         push.first.report_kind = under ? cvfm_pkg::KIND_UNDER : cvfm_pkg::KIND_OVER;
         push.first.still_init  = 1'b0;
         push.first.shutdown    = 1'b1;
         push.first.last        = 1'b1;
      end else begin
         push.first.report_kind = cvfm_pkg::KIND_VOLTAGE;
         push.first.still_init  = init;
         push.first.shutdown    = 1'b0;
         push.first.last        = !tfault;
      end
      if (wr_en) begin
         push.count = tfault ? 2'd2 : 2'd1;
         if (vfault || tfault) begin
            tripped_in = 1'b1;
         end else if (s1_item_ff.thermal_alarm && otc_ff != cvfm_pkg::COUNT_MAX) begin
            otc_in = 16'(otc_ff + 16'd1);
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (in_take) begin
         s1_valid_in = 1'b1;
      end else if (proc) begin
         s1_valid_in = 1'b0;
      end
      ent_valid_in = ent_valid_ff;
      lw_valid_in  = lw_valid_ff;
      lw_addr_in   = lw_addr_ff;
      lw_rec_in    = lw_rec_ff;
      if (wr_en) begin
         for (int i = 0; i < cvfm_pkg::SLAVE_COUNT; i++) begin
            if (addr == AW'(i)) begin
               ent_valid_in[i] = 1'b1;
            end
         end
         lw_valid_in = 1'b1;
         lw_addr_in  = addr;
         lw_rec_in   = rec_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         ent_valid_ff <= '0;
         lw_valid_ff  <= 1'b0;
         tripped_ff   <= 1'b0;
         otc_ff       <= 16'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         ent_valid_ff <= ent_valid_in;
         lw_valid_ff  <= lw_valid_in;
         tripped_ff   <= tripped_in;
         otc_ff       <= otc_in;
      end
      lw_addr_ff <= lw_addr_in;
      lw_rec_ff  <= lw_rec_in;
      if (in_take) begin
         s1_item_ff <= in_item;
      end
   end

   assign push_shut = (push.count == 2'd2) ? push.second.shutdown : push.first.shutdown;

   `CVFM_ASSERT_IMPL(a_no_result_after_trip, clock, reset, tripped_ff, push.count == 2'd0)
   `CVFM_ASSERT_NEXT(a_shutdown_latches, clock, reset, push.count != 2'd0 && push_shut, tripped_ff)
   `CVFM_ASSERT_NEXT(a_writeback_tracked, clock, reset, wr_en, lw_valid_ff && lw_addr_ff == $past(addr))

endmodule

`default_nettype wire

// ===== sv/cvfm_rsp_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on cvfm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "cell_voltage_fault_monitor_core_defines.svh"

module cvfm_rsp_fifo (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cvfm_pkg::push_type            push,
   input  wire logic                          pop,
   output cvfm_pkg::rsp_type                  head,
   output logic                               not_empty,
   output logic [cvfm_pkg::RSP_CW-1:0]        level
);

   localparam int PW = cvfm_pkg::RSP_PW;
   localparam int CW = cvfm_pkg::RSP_CW;

   cvfm_pkg::rsp_type entry_ff [cvfm_pkg::RSP_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [PW-1:0]     wr_ptr_next;

   assign wr_ptr_next = PW'(wr_ptr_ff + PW'(1));
   assign wr_ptr_in   = PW'(wr_ptr_ff + PW'(push.count));
   assign rd_ptr_in   = pop ? PW'(rd_ptr_ff + PW'(1)) : rd_ptr_ff;
   assign count_in    = CW'(count_ff + CW'(push.count) - CW'(pop));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.second;
      end
   end

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign level     = count_ff;

   `CVFM_ASSERT_IMPL(a_level_bound, clock, reset, 1'b1, count_ff <= CW'(cvfm_pkg::RSP_DEPTH))
   `CVFM_ASSERT_IMPL(a_pop_nonempty, clock, reset, pop, count_ff != '0)

endmodule

`default_nettype wire

// ===== sv/cell_voltage_fault_monitor_core.sv =====
// A sample taken on req is decided in the stage register, then its results pass through
// the result queue to rsp. Throughput: 1 sample per cycle when req is not stalled. The
// state RAM is read at the req transfer and written back as the stage retires, with the
// last write forwarded. req stalls while the result queue holds more than two results.
// An over-temperature trip gives two rsp transfers.
// Reset (synchronous): default limits, slaves init with zero counts, trip cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "cell_voltage_fault_monitor_core_defines.svh"

module cell_voltage_fault_monitor_core (
   input  wire logic              clock,
   input  wire logic              reset,
   // sample channel
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire cvfm_pkg::req_type req_data,
   // result channel
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output cvfm_pkg::rsp_type      rsp_data,
   // register write port
   input  wire logic              csr_we,
   input  wire logic [1:0]        csr_index,
   input  wire logic [15:0]       csr_wdata
);

   logic [15:0] low_limit_ff, low_limit_in;
   logic [15:0] high_limit_ff, high_limit_in;
   logic [15:0] debounce_ff, debounce_in;

   logic                           take;
   logic                           advance;
   logic                           busy;
   logic                           pop;
   logic [cvfm_pkg::RSP_CW-1:0]    level;
   cvfm_pkg::push_type             push;

   // Register writes: unknown indexes are dropped.
   always_comb begin
      low_limit_in  = low_limit_ff;
      high_limit_in = high_limit_ff;
      debounce_in   = debounce_ff;
      if (csr_we) begin
         unique case (csr_index)
            cvfm_pkg::CSR_LOW_LIMIT:  low_limit_in  = csr_wdata;
            cvfm_pkg::CSR_HIGH_LIMIT: high_limit_in = csr_wdata;
            cvfm_pkg::CSR_DEBOUNCE:   debounce_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_limit_ff  <= cvfm_pkg::LOW_LIMIT_RESET;
         high_limit_ff <= cvfm_pkg::HIGH_LIMIT_RESET;
         debounce_ff   <= cvfm_pkg::DEBOUNCE_RESET;
      end else begin
         low_limit_ff  <= low_limit_in;
         high_limit_ff <= high_limit_in;
         debounce_ff   <= debounce_in;
      end
   end

   // The decision stage retires its sample only while the queue has room for
   // two results; a new sample enters whenever the stage is empty or retiring.
   assign advance   = level <= cvfm_pkg::RSP_CW'(cvfm_pkg::RSP_DEPTH - 2);
   assign req_ready = !busy || advance;
   assign take      = req_valid && req_ready;

   cvfm_slave_stage u_stage (
      .clock     (clock),
      .reset     (reset),
      .in_take   (take),
      .in_item   (req_data),
      .advance   (advance),
      .low_limit (low_limit_ff),
      .high_limit(high_limit_ff),
      .debounce  (debounce_ff),
      .busy      (busy),
      .push      (push)
   );

   // Results queue up here so the sample side keeps moving while rsp stalls.
   assign pop = rsp_valid && rsp_ready;

   cvfm_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (pop),
      .head     (rsp_data),
      .not_empty(rsp_valid),
      .level    (level)
   );

   `CVFM_ASSERT_IMPL(a_push_has_room, clock, reset, push.count != 2'd0,
                     level <= cvfm_pkg::RSP_CW'(cvfm_pkg::RSP_DEPTH - 2))

endmodule

`default_nettype wire

// ===== tb/sv/cvfm_checker.sv =====
// Result checker for the cell voltage fault monitor: predicts every result and compares.
// Depends on cvfm_pkg for the payload types, report kinds, modes and register indexes.
`timescale 1ns / 1ps

module cvfm_checker
   import cvfm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire req_type     req_data,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire rsp_type     rsp_data,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   output int               reports_due,
   output int               mismatches
);

   logic [15:0] low_limit;
   logic [15:0] high_limit;
   logic [15:0] debounce;
   logic [1:0]  mode [SLAVE_COUNT];
   logic [15:0] fault_count [SLAVE_COUNT];
   logic [15:0] temp_count;
   logic        tripped;
   rsp_type     due_reports [$];
   int          error_total = 0;

   function automatic rsp_type make_report(input logic [1:0] kind, input logic [3:0] seg,
                                           input logic [3:0] cell_no, input logic [15:0] value,
                                           input logic init, input logic shut,
                                           input logic last);
      rsp_type r;
      r.report_kind = kind;
      r.segment_id  = seg;
      r.cell_number = cell_no;
      r.cell_value  = value;
      r.still_init  = init;
      r.shutdown    = shut;
      r.last        = last;
      return r;
   endfunction

   // Advance the monitor state by one sample and queue the reports it causes.
   task automatic judge_sample(input req_type s);
      int unsigned idx;
      logic        under;
      logic        over;
      logic        init;
      idx = 32'(s.slave_index);
      if (tripped || idx >= SLAVE_COUNT) return;
      if (s.cell_code != 16'd0 && mode[idx] == MODE_INIT) mode[idx] = MODE_NORMAL;
      init  = (mode[idx] == MODE_INIT);
      under = (s.cell_code < low_limit);
      over  = (s.cell_code >= high_limit);
      if (mode[idx] == MODE_NORMAL) begin
         if ((under || over) && fault_count[idx] != COUNT_MAX)
            fault_count[idx] = fault_count[idx] + 16'd1;
         if (fault_count[idx] > debounce && (under || over)) begin
            mode[idx] = MODE_ERROR;
            tripped   = 1'b1;
            due_reports.push_back(make_report(under ? KIND_UNDER : KIND_OVER, s.slave_index,
                                              s.cell_index, s.cell_code, 1'b0, 1'b1, 1'b1));
            return;
         end
      end
      if (temp_count > debounce) begin
         tripped = 1'b1;
         due_reports.push_back(make_report(KIND_VOLTAGE, s.slave_index, s.cell_index,
                                           s.cell_code, init, 1'b0, 1'b0));
         due_reports.push_back(make_report(KIND_TEMP, 4'd0, 4'd0, 16'd0, 1'b0, 1'b1, 1'b1));
         return;
      end
      if (s.thermal_alarm && temp_count != COUNT_MAX) temp_count = temp_count + 16'd1;
      due_reports.push_back(make_report(KIND_VOLTAGE, s.slave_index, s.cell_index,
                                        s.cell_code, init, 1'b0, 1'b1));
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         error_total++;
         if (error_total <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         low_limit  = LOW_LIMIT_RESET;
         high_limit = HIGH_LIMIT_RESET;
         debounce   = DEBOUNCE_RESET;
         for (int i = 0; i < SLAVE_COUNT; i++) begin
            mode[i]        = MODE_INIT;
            fault_count[i] = 16'd0;
         end
         temp_count = 16'd0;
         tripped    = 1'b0;
         due_reports.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LOW_LIMIT:  low_limit  = csr_wdata;
               CSR_HIGH_LIMIT: high_limit = csr_wdata;
               CSR_DEBOUNCE:   debounce   = csr_wdata;
               default: ;
            endcase
         end
         // pop before push: a result can never belong to a sample taken at the same edge
         if (rsp_valid && rsp_ready) begin
            if (due_reports.size() == 0) begin
               error_total++;
               if (error_total <= 10)
                  $display("%0t: result with nothing expected, kind %0d", $realtime,
                           rsp_data.report_kind);
            end else begin
               want = due_reports.pop_front();
               check_field("report_kind", 16'(want.report_kind), 16'(rsp_data.report_kind));
               check_field("segment_id", 16'(want.segment_id), 16'(rsp_data.segment_id));
               check_field("cell_number", 16'(want.cell_number), 16'(rsp_data.cell_number));
               check_field("cell_value", want.cell_value, rsp_data.cell_value);
               check_field("still_init", 16'(want.still_init), 16'(rsp_data.still_init));
               check_field("shutdown", 16'(want.shutdown), 16'(rsp_data.shutdown));
               check_field("last", 16'(want.last), 16'(rsp_data.last));
            end
         end
         if (req_valid && req_ready) judge_sample(req_data);
      end
      reports_due <= due_reports.size();
      mismatches  <= error_total;
   end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the cell voltage fault monitor testbench: clock, reset, stimulus and verdict.
// Depends on cvfm_pkg, cvfm_checker and cell_voltage_fault_monitor_core.
`timescale 1ns / 1ps

module tb;
   import cvfm_pkg::*;

   localparam int WATCHDOG_LIMIT   = 2000;  // cycles without any transfer
   localparam int HOLD_CYCLES      = 300;   // long receiver hold-off
   localparam int DRAIN_CYCLES     = 4;     // ignored samples need slack
   localparam int TAIL_CYCLES      = 20;
   localparam int RANDOM_PHASES    = 5;
   localparam int PHASE_SAMPLES    = 72;
   localparam int BURST_SAMPLES    = 24;
   localparam int POST_TRIP        = 6;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_we    = 1'b0;
   logic [1:0]  csr_index = CSR_LOW_LIMIT;
   logic [15:0] csr_wdata = '0;

   int reports_due;
   int mismatches;
   int stall_cycles = 0;

   // handshake shaping shared by the sender and the receiver
   bit idle_on     = 1'b1;
   bit hold_rsp    = 1'b0;
   bit hold_active = 1'b0;

   // limits as last written, used to aim codes at the thresholds
   logic [15:0] cur_low  = LOW_LIMIT_RESET;
   logic [15:0] cur_high = HIGH_LIMIT_RESET;

   always #5 clock = ~clock;

   cell_voltage_fault_monitor_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cvfm_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .reports_due (reports_due),
      .mismatches  (mismatches)
   );

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned gap_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
      return $urandom_range(0, 3);
   endfunction

   function automatic req_type sample(input int unsigned slave, input int unsigned cell_no,
                                      input int unsigned code, input bit alarm);
      req_type s;
      s.slave_index   = 4'(slave);
      s.cell_index    = 4'(cell_no);
      s.cell_code     = 16'(code);
      s.thermal_alarm = alarm;
      return s;
   endfunction

   // Random sample: mostly valid slaves, codes clustered on the current thresholds.
   function automatic req_type random_sample();
      req_type s;
      s.slave_index   = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                                    : 4'($urandom_range(0, SLAVE_COUNT - 1));
      s.cell_index    = 4'($urandom_range(0, 15));
      s.thermal_alarm = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
         0:       s.cell_code = 16'd0;
         1:       s.cell_code = 16'hFFFF;
         2:       s.cell_code = cur_low - 16'd1;
         3:       s.cell_code = cur_low;
         4:       s.cell_code = cur_high - 16'd1;
         5:       s.cell_code = cur_high;
         default: s.cell_code = 16'($urandom);
      endcase
      return s;
   endfunction

   // One transfer on the sample channel, then an optional idle gap.
   // Called at a rising edge; valid stays high across back-to-back items.
   task automatic send_sample(input req_type item);
      int unsigned gap;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (idle_on) begin
         gap = gap_len();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stop offering and wait until every predicted result has been seen.
   // The first edge makes sure the checker has counted the last transfer.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (reports_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Registers only change while the block is idle.
   task automatic set_regs(input logic [15:0] low, input logic [15:0] high,
                           input logic [15:0] deb);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= CSR_LOW_LIMIT;
      csr_wdata <= low;
      @(posedge clock);
      csr_index <= CSR_HIGH_LIMIT;
      csr_wdata <= high;
      @(posedge clock);
      csr_index <= CSR_DEBOUNCE;
      csr_wdata <= deb;
      @(posedge clock);
      csr_we   <= 1'b0;
      cur_low  = low;
      cur_high = high;
   endtask

   // Receiver: runs of ready and stalls of random length. A hold request
   // from the stimulus turns into one long stall counted here.
   initial begin : rsp_side
      int unsigned span;
      logic        level;
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp    = 1'b0;
            hold_active = 1'b1;
            level       = 1'b0;
            span        = HOLD_CYCLES;
         end else if (!idle_on) begin
            level = 1'b1;
            span  = 1;
         end else begin
            level = ($urandom_range(0, 2) != 0);
            span  = level ? $urandom_range(1, 12) : gap_len() + 1;
         end
         rsp_ready <= level;
         repeat (span) @(posedge clock);
         hold_active = 1'b0;
      end
   end

   // Watchdog: any transfer on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [15:0] low;
      logic [15:0] high;
      logic [15:0] deb;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // --- directed, reset limits with zero debounce ---
      // Any counted fault or alarm would trip at once here, so the samples stay
      // in range or hit init slaves; only the last one has its alarm counted.
      send_sample(sample(0, 0, 0, 0));          // zero code keeps slave in init
      send_sample(sample(9, 15, 0, 0));         // top slave, top cell, still init
      send_sample(sample(10, 3, 16'hFFFF, 1));  // slave out of range: ignored
      send_sample(sample(15, 15, 16'hFFFF, 1)); // all ones slave index: ignored
      send_sample(sample(1, 5, 45000, 0));      // init -> normal, in range
      send_sample(sample(2, 6, 33990, 0));      // at low limit: not under
      send_sample(sample(3, 7, 57102, 0));      // just below high limit
      send_sample(sample(4, 8, 45000, 1));      // alarm counts once

      // --- widest window: nothing under, only full scale over ---
      set_regs(16'd0, 16'hFFFF, 16'hFFFF);
      send_sample(sample(0, 1, 0, 1));          // code zero not under with low limit zero
      send_sample(sample(1, 2, 16'hFFFF, 0));   // over, counted, no trip at max debounce
      send_sample(sample(5, 10, 16'hFFFE, 1));  // just below high limit

      // --- crossed limits: every code but full scale is both under and over, under wins ---
      set_regs(16'hFFFF, 16'd0, 16'hFFFF);
      send_sample(sample(1, 4, 100, 0));
      send_sample(sample(6, 9, 16'hFFFF, 1));   // full scale is only over
      send_sample(sample(0, 0, 0, 0));          // init slave is never counted
      send_sample(sample(12, 5, 1234, 1));      // ignored

      // --- random phases, debounce always above any reachable count ---
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         deb = 16'($urandom_range(2000, 65535));
         case (p)
            0: begin
               low  = LOW_LIMIT_RESET;
               high = HIGH_LIMIT_RESET;
               deb  = 16'hFFFF;
            end
            1: begin
               low  = 16'($urandom_range(0, 32767));
               high = 16'($urandom_range(32768, 65535));
            end
            2: begin
               low  = 16'($urandom_range(100, 30000));
               high = low + 16'd1;
            end
            3: begin
               high = 16'($urandom_range(0, 32767));
               low  = 16'($urandom_range(32768, 65535));
            end
            default: begin
               low  = 16'($urandom);
               high = 16'($urandom);
            end
         endcase
         set_regs(low, high, deb);
         idle_on = (p != 1);  // one phase at full rate on both sides
         for (int i = 0; i < PHASE_SAMPLES; i++) begin
            if (p == 2 && i == PHASE_SAMPLES / 2) begin
               // back up the result queue until the block stops taking samples
               hold_rsp = 1'b1;
               wait (hold_active);
               for (int k = 0; k < BURST_SAMPLES; k++) begin
                  idle_on = 1'b0;
                  send_sample(random_sample());
               end
               idle_on = 1'b1;
            end
            send_sample(random_sample());
         end
         idle_on = 1'b1;
      end

      // --- zero debounce: the next qualifying sample trips ---
      // The alarm counter is already above zero, so an in-range sample trips on
      // over-temperature after its voltage report.
      set_regs(LOW_LIMIT_RESET, HIGH_LIMIT_RESET, 16'd0);
      case ($urandom_range(0, 2))
         0:       send_sample(sample(7, 3, 16'h0100, 0));   // under-voltage trip
         1:       send_sample(sample(7, 3, 16'hFFFF, 0));   // over-voltage trip
         default: send_sample(sample(8, 3, 45000, 1));      // report plus over-temperature
      endcase
      // after the trip everything is ignored
      for (int i = 0; i < POST_TRIP; i++)
         send_sample(random_sample());

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && reports_due == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
